>>> rtl/core/bks_pkg.sv
`timescale 1ns / 1ps

package bks_pkg;

  // Fixed field widths of the command and result channels.
  localparam int KEY_W  = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // Default sizes.
  localparam int BUCKETS_DEF      = 97;
  localparam int POOL_ENTRIES_DEF = 4096;

  // Command codes. The spare code is carried out as a look-up.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

endpackage

>>> rtl/core/bks_if.sv
`timescale 1ns / 1ps

// Command channel.
interface bks_in_if;
  logic                        valid;
  logic                        ready;
  logic [bks_pkg::CMD_W-1:0]   command;
  logic [bks_pkg::KEY_W-1:0]   key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

// Result channel.
interface bks_out_if #(
  parameter int OCC_W = 13
);
  logic                        valid;
  logic                        ready;
  logic [bks_pkg::STAT_W-1:0]  status;
  logic [OCC_W-1:0]            occupancy;

  modport source (output valid, output status, output occupancy, input ready);
  modport sink   (input valid, input status, input occupancy, output ready);
endinterface

>>> rtl/core/bks_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module bks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bks_front.sv
`timescale 1ns / 1ps

// Front end: takes a command and works out the key's bucket in fold, reciprocal and
// remainder phases. The four key bytes are folded into a short weighted sum that
// keeps the remainder, and the sum is reduced with a reciprocal multiply. The
// classified command is then handed to the queue.
module bks_front #(
  parameter int BUCKETS = bks_pkg::BUCKETS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  bks_in_if.sink                  in_ch,
  output logic                    q_valid,
  input  logic                    q_ready,
  output logic [bks_pkg::CMD_W+bks_pkg::KEY_W+$clog2(BUCKETS)-1:0] q_data
);

  localparam int BW = $clog2(BUCKETS);
  // The weighted byte sum stays below 2^SW.
  localparam int SW = BW + 10;
  // The reciprocal is exact for every sum below 2^SW with this shift.
  localparam int SH = SW + BW;
  localparam int MW = SW + 2;
  localparam int XW = SW + MW;
  localparam logic [SW-1:0] W1    = SW'(256 % BUCKETS);
  localparam logic [SW-1:0] W2    = SW'(65536 % BUCKETS);
  localparam logic [SW-1:0] W3    = SW'((1 << 24) % BUCKETS);
  localparam logic [SW-1:0] BDIV  = SW'(BUCKETS);
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  typedef enum logic [1:0] {PH_FOLD, PH_RECIP, PH_REM} phase_t;

  logic                       busy_r;
  logic                       done_r;
  phase_t                     ph_r;
  logic [bks_pkg::CMD_W-1:0]  cmd_r;
  logic [bks_pkg::KEY_W-1:0]  key_r;
  logic [SW-1:0]              sum_r;
  logic [SW-1:0]              quo_r;
  logic [BW-1:0]              rem_r;
  logic [SW-1:0]              sum_nxt;
  logic [XW-1:0]              prod;
  logic [SW-1:0]              quo_nxt;
  logic [SW-1:0]              diff;

  // Byte fold, quotient estimate and remainder, one per phase.
  always_comb begin
    sum_nxt = SW'(key_r[7:0])
            + SW'(key_r[15:8]) * W1
            + SW'(key_r[23:16]) * W2
            + SW'(key_r[31:24]) * W3;
    prod    = XW'(sum_r) * XW'(RECIP);
    quo_nxt = SW'(prod >> SH);
    diff    = sum_r - quo_r * BDIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_FOLD;
    end else if (!busy_r) begin
      if (in_ch.valid) begin
        busy_r <= 1'b1;
        cmd_r  <= in_ch.command;
        key_r  <= in_ch.key;
        ph_r   <= PH_FOLD;
      end
    end else if (!done_r) begin
      unique case (ph_r)
        PH_FOLD: begin
          sum_r <= sum_nxt;
          ph_r  <= PH_RECIP;
        end
        PH_RECIP: begin
          quo_r <= quo_nxt;
          ph_r  <= PH_REM;
        end
        PH_REM: begin
          rem_r  <= diff[BW-1:0];
          done_r <= 1'b1;
        end
        default: begin
          ph_r <= PH_FOLD;
        end
      endcase
    end else if (q_ready) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end
  end

  assign in_ch.ready = !busy_r;
  assign q_valid     = busy_r && done_r;
  assign q_data      = {cmd_r, key_r, rem_r};

endmodule

>>> rtl/core/bks_queue.sv
`timescale 1ns / 1ps

// Two-entry queue between the front and back ends.
module bks_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] slot_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wp_r] <= wr_data;
        wp_r         <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/core/bks_back.sv
`timescale 1ns / 1ps

// Back end: walks the bucket run in the entry memories and carries out the
// insert, erase or look-up, then presents the result in an output register.
module bks_back #(
  parameter int BUCKETS      = bks_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = bks_pkg::POOL_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  logic [bks_pkg::CMD_W+bks_pkg::KEY_W+$clog2(BUCKETS)-1:0] q_data,
  bks_out_if.source out_ch
);

  localparam int BW = $clog2(BUCKETS);
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 2);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int KW = bks_pkg::KEY_W;
  localparam logic [LW-1:0] TAIL = LW'(POOL_ENTRIES);
  localparam logic [LW-1:0] HEAD = LW'(POOL_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HEAD, S_WALK, S_DECIDE,
    S_INS_RD, S_INS_WR, S_INS_LINK, S_ERA_WR, S_ERA_FIN, S_RESP
  } state_t;

  state_t                      st_r;
  logic [BW-1:0]               clr_r;
  logic [bks_pkg::CMD_W-1:0]   cmd_r;
  logic [KW-1:0]               key_r;
  logic [BW-1:0]               b_r;
  logic [LW-1:0]               p_r;
  logic [LW-1:0]               head_r;
  logic [LW-1:0]               pr_r;
  logic [LW-1:0]               nx_r;
  logic                        found_r;
  logic                        fresh_r;
  logic [LW-1:0]               fh_r;
  logic [CW-1:0]               virgin_r;
  logic [CW-1:0]               held_r;
  logic [LW-1:0]               tail_prev_r;
  logic [bks_pkg::STAT_W-1:0]  status_r;
  logic                        out_valid_r;
  logic [bks_pkg::STAT_W-1:0]  out_status_r;
  logic [CW-1:0]               out_occ_r;
  logic                        out_free;
  logic                        resp_fire;

  // Memory ports.
  logic          key_we, bkt_we, nxt_we, prv_we, bh_we;
  logic [PW-1:0] key_wa, bkt_wa, nxt_wa, prv_wa;
  logic [PW-1:0] key_ra, bkt_ra, nxt_ra, prv_ra;
  logic [BW-1:0] bh_wa, bh_ra;
  logic [KW-1:0] key_wd, key_rd;
  logic [BW-1:0] bkt_wd, bkt_rd;
  logic [LW-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd, bh_wd, bh_rd;

  bks_ram #(.WIDTH(KW), .DEPTH(POOL_ENTRIES)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
  bks_ram #(.WIDTH(BW), .DEPTH(POOL_ENTRIES)) u_bkt (
    .clk, .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_rd));
  bks_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
  bks_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_prv (
    .clk, .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(prv_ra), .rdata(prv_rd));
  bks_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bh (
    .clk, .we(bh_we), .waddr(bh_wa), .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_rd));

  // Unpacked queue item.
  logic [bks_pkg::CMD_W-1:0] q_cmd;
  logic [KW-1:0]             q_key;
  logic [BW-1:0]             q_bkt;
  assign {q_cmd, q_key, q_bkt} = q_data;

  assign q_ready   = (st_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign resp_fire = (st_r == S_RESP) && out_free;

  // Free entry that follows the current free head.
  logic [LW-1:0] fh_succ;
  assign fh_succ = fresh_r ? ((fh_r == '0) ? TAIL : fh_r - 1'b1) : nxt_rd;

  // Memory control per state.
  always_comb begin
    key_we = 1'b0; bkt_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0; bh_we = 1'b0;
    key_wa = p_r[PW-1:0]; bkt_wa = fh_r[PW-1:0];
    nxt_wa = fh_r[PW-1:0]; prv_wa = fh_r[PW-1:0];
    key_wd = key_r; bkt_wd = b_r; nxt_wd = p_r; prv_wd = pr_r;
    key_ra = p_r[PW-1:0]; bkt_ra = p_r[PW-1:0];
    nxt_ra = p_r[PW-1:0]; prv_ra = p_r[PW-1:0];
    bh_wa = b_r; bh_wd = TAIL; bh_ra = q_bkt;
    unique case (st_r)
      S_CLR: begin
        bh_we = 1'b1;
        bh_wa = clr_r;
      end
      S_HEAD: begin
        key_ra = bh_rd[PW-1:0]; bkt_ra = bh_rd[PW-1:0];
        nxt_ra = bh_rd[PW-1:0]; prv_ra = bh_rd[PW-1:0];
      end
      S_WALK: begin
        key_ra = nxt_rd[PW-1:0]; bkt_ra = nxt_rd[PW-1:0];
        nxt_ra = nxt_rd[PW-1:0]; prv_ra = nxt_rd[PW-1:0];
      end
      S_INS_RD: begin
        nxt_ra = fh_r[PW-1:0];
      end
      S_INS_WR: begin
        key_we = 1'b1; key_wa = fh_r[PW-1:0];
        bkt_we = 1'b1;
        prv_we = 1'b1;
        nxt_we = 1'b1;
      end
      S_INS_LINK: begin
        // Here fh_r already holds the next free entry; nx_r holds the new one.
        nxt_we = (pr_r < TAIL); nxt_wa = pr_r[PW-1:0]; nxt_wd = nx_r;
        prv_we = (p_r < TAIL);  prv_wa = p_r[PW-1:0];  prv_wd = nx_r;
        bh_we  = (head_r >= TAIL); bh_wd = nx_r;
      end
      S_ERA_WR: begin
        nxt_we = (pr_r < TAIL); nxt_wa = pr_r[PW-1:0]; nxt_wd = nx_r;
        prv_we = (nx_r < TAIL); prv_wa = nx_r[PW-1:0]; prv_wd = pr_r;
        bkt_ra = nx_r[PW-1:0];
      end
      S_ERA_FIN: begin
        nxt_we = 1'b1; nxt_wa = p_r[PW-1:0]; nxt_wd = fh_r;
        bh_we  = (head_r == p_r);
        bh_wd  = ((nx_r < TAIL) && (bkt_rd == b_r)) ? nx_r : TAIL;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      held_r      <= '0;
      virgin_r    <= CW'(POOL_ENTRIES);
      fh_r        <= LW'(POOL_ENTRIES - 1);
      tail_prev_r <= HEAD;
      out_valid_r <= 1'b0;
    end else begin
      // A new result loads the output register; a transfer empties it.
      if (resp_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BW'(BUCKETS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            key_r <= q_key;
            b_r   <= q_bkt;
            st_r  <= S_HEAD;
          end
        end
        S_HEAD: begin
          head_r <= bh_rd;
          p_r    <= bh_rd;
          if (bh_rd >= TAIL) begin
            found_r <= 1'b0;
            pr_r    <= tail_prev_r;
            st_r    <= S_DECIDE;
          end else begin
            st_r <= S_WALK;
          end
        end
        S_WALK: begin
          // Entry data of p_r is on the read ports.
          if (bkt_rd != b_r) begin
            found_r <= 1'b0;
            pr_r    <= prv_rd;
            st_r    <= S_DECIDE;
          end else if (key_rd == key_r) begin
            found_r <= 1'b1;
            pr_r    <= prv_rd;
            nx_r    <= nxt_rd;
            st_r    <= S_DECIDE;
          end else begin
            p_r <= nxt_rd;
            if (nxt_rd >= TAIL) begin
              found_r <= 1'b0;
              pr_r    <= tail_prev_r;
              st_r    <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          fresh_r <= (fh_r < LW'(virgin_r));
          case (cmd_r)
            bks_pkg::CMD_INSERT: begin
              if (found_r) begin
                status_r <= bks_pkg::ST_DUP;
                st_r     <= S_RESP;
              end else if (held_r == CW'(POOL_ENTRIES)) begin
                status_r <= bks_pkg::ST_FULL;
                st_r     <= S_RESP;
              end else if (fh_r < LW'(virgin_r)) begin
                st_r <= S_INS_WR;
              end else begin
                st_r <= S_INS_RD;
              end
            end
            bks_pkg::CMD_ERASE: begin
              if (found_r) begin
                st_r <= S_ERA_WR;
              end else begin
                status_r <= bks_pkg::ST_ABSENT;
                st_r     <= S_RESP;
              end
            end
            default: begin
              status_r <= found_r ? bks_pkg::ST_OK : bks_pkg::ST_ABSENT;
              st_r     <= S_RESP;
            end
          endcase
        end
        S_INS_RD: begin
          st_r <= S_INS_WR;
        end
        S_INS_WR: begin
          nx_r <= fh_r;
          fh_r <= fh_succ;
          if (fresh_r) virgin_r <= virgin_r - 1'b1;
          st_r <= S_INS_LINK;
        end
        S_INS_LINK: begin
          if (p_r >= TAIL) tail_prev_r <= nx_r;
          held_r   <= held_r + 1'b1;
          status_r <= bks_pkg::ST_OK;
          st_r     <= S_RESP;
        end
        S_ERA_WR: begin
          if (nx_r >= TAIL) tail_prev_r <= pr_r;
          st_r <= S_ERA_FIN;
        end
        S_ERA_FIN: begin
          fh_r     <= p_r;
          held_r   <= held_r - 1'b1;
          status_r <= bks_pkg::ST_OK;
          st_r     <= S_RESP;
        end
        S_RESP: begin
          if (resp_fire) begin
            out_status_r <= status_r;
            out_occ_r    <= held_r;
            st_r         <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;

endmodule

>>> rtl/core/bucketed_key_set_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                       Handshake
// in_ch     in   command[1:0], key[31:0]       valid/ready, transfer on both high
// out_ch    out  status[1:0], occupancy[12:0]  valid/ready, transfer on both high
//
// The front end takes a new command only after handing the last one on: it folds
// the key and reduces it to its bucket, then hands it to a two-entry queue.
// The back end reads the bucket head, then one entry of the bucket run at a time,
// and then writes the links for an erase or an insert, with one read per memory.
// After reset every entry of the bucket head memory is cleared before
// the first command is executed. Either side may stall without losing data.
module bucketed_key_set_top #(
  parameter int BUCKETS      = bks_pkg::BUCKETS_DEF,
  parameter int POOL_ENTRIES = bks_pkg::POOL_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bks_in_if.sink    in_ch,
  bks_out_if.source out_ch
);

  localparam int DW = bks_pkg::CMD_W + bks_pkg::KEY_W + $clog2(BUCKETS);

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  logic [DW-1:0] fq_data, qb_data;

  bks_front #(.BUCKETS(BUCKETS)) u_front (
    .clk, .rst_n, .in_ch,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

  bks_queue #(.DW(DW)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data));

  bks_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
    .clk, .rst_n,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_ch);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NBKT = 97;
  localparam int POOL = 4096;
  localparam int TAILM = POOL;
  localparam int HEADM = POOL + 1;
  localparam int N_RAND = 930;

  typedef struct packed {
    logic [bks_pkg::STAT_W-1:0] status;
    logic [12:0]                occupancy;
  } answer_t;

  typedef struct {
    logic [bks_pkg::CMD_W-1:0] command;
    logic [bks_pkg::KEY_W-1:0] key;
    logic                      has_fixed;
    answer_t                   fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bks_in_if  in_ch ();
  bks_out_if #(.OCC_W(13)) out_ch ();

  bucketed_key_set_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the set: pool, links, bucket heads, free list.
  logic [31:0] sh_key    [POOL];
  int          sh_bucket [POOL];
  int          sh_next   [POOL+2];
  int          sh_prev   [POOL+2];
  int          sh_head   [NBKT];
  int          sh_free;
  int          sh_count;

  answer_t answers_due[$];
  int      mismatches = 0;
  int      stray = 0;
  bit      no_idle = 1'b0;

  function automatic int fix_link(int v);
    return (v >= 0 && v < POOL + 2) ? v : TAILM;
  endfunction

  function automatic void set_clear();
    for (int i = 0; i < POOL; i++) begin
      sh_key[i] = '0;
      sh_bucket[i] = 0;
      sh_next[i] = (i == 0) ? TAILM : i - 1;
      sh_prev[i] = 0;
    end
    sh_next[HEADM] = TAILM;
    sh_next[TAILM] = TAILM;
    sh_prev[TAILM] = HEADM;
    sh_prev[HEADM] = HEADM;
    for (int b = 0; b < NBKT; b++) sh_head[b] = TAILM;
    sh_free = POOL - 1;
    sh_count = 0;
  endfunction

  // Applies one command to the shadow set and returns the expected answer.
  function automatic answer_t set_apply(logic [bks_pkg::CMD_W-1:0] cmd, logic [31:0] k);
    int b, p, hit, stop, steps, n, pr, nx;
    answer_t a;
    b = int'(k % NBKT);
    p = fix_link(sh_head[b]);
    hit = TAILM;
    steps = 0;
    while (p < POOL && sh_bucket[p] == b && steps < POOL) begin
      if (sh_key[p] == k) begin
        hit = p;
        break;
      end
      p = fix_link(sh_next[p]);
      steps++;
    end
    stop = p;
    if (cmd == bks_pkg::CMD_INSERT) begin
      if (hit != TAILM) a.status = bks_pkg::ST_DUP;
      else if (sh_count >= POOL || sh_free >= POOL) a.status = bks_pkg::ST_FULL;
      else begin
        n = sh_free;
        pr = fix_link(sh_prev[stop]);
        sh_free = fix_link(sh_next[n]);
        sh_key[n] = k;
        sh_bucket[n] = b;
        sh_prev[n] = pr;
        sh_next[pr] = n;
        sh_next[n] = stop;
        sh_prev[stop] = n;
        if (sh_head[b] == TAILM) sh_head[b] = n;
        sh_count++;
        a.status = bks_pkg::ST_OK;
      end
    end else if (cmd == bks_pkg::CMD_ERASE) begin
      if (hit == TAILM) a.status = bks_pkg::ST_ABSENT;
      else begin
        pr = fix_link(sh_prev[hit]);
        nx = fix_link(sh_next[hit]);
        sh_next[pr] = nx;
        sh_prev[nx] = pr;
        if (sh_head[b] == hit)
          sh_head[b] = (nx < POOL && sh_bucket[nx] == b) ? nx : TAILM;
        sh_next[hit] = sh_free;
        sh_free = hit;
        if (sh_count > 0) sh_count--;
        a.status = bks_pkg::ST_OK;
      end
    end else begin
      a.status = (hit == TAILM) ? bks_pkg::ST_ABSENT : bks_pkg::ST_OK;
    end
    a.occupancy = 13'(sh_count);
    return a;
  endfunction

  function automatic void note_mismatch(string what, answer_t exp_a, answer_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected status %0d occ %0d, got status %0d occ %0d",
               what, exp_a.status, exp_a.occupancy, got.status, got.occupancy);
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 37);
  endfunction

  // Key whose bucket is fixed, for crowding one chain. The multiplier range
  // keeps the key below 2^32 so that no wrap moves it to another bucket.
  function automatic logic [31:0] key_in_bucket(int b);
    return 32'($urandom_range(32'd44278012) * NBKT + b);
  endfunction

  // Sends one command, waiting for the transfer. Valid stays high into the
  // next command unless that one starts with idle cycles.
  task automatic send_cmd(logic [bks_pkg::CMD_W-1:0] cmd, logic [31:0] k, bit has_fixed,
                          answer_t fixed);
    answer_t a;
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    a = set_apply(cmd, k);
    if (has_fixed && a != fixed) note_mismatch("table", fixed, a);
    answers_due.insert(answers_due.size(), a);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: random back-pressure and compare on each transfer.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (answers_due.size() == 0) begin
        stray++;
        note_mismatch("unexpected", '0, {out_ch.status, out_ch.occupancy});
      end else begin
        answer_t e;
        e = answers_due[0];
        answers_due.delete(0);
        if (e.status !== out_ch.status || e.occupancy !== out_ch.occupancy)
          note_mismatch("result", e, {out_ch.status, out_ch.occupancy});
      end
    end
  end

  // Directed table.
  stim_row_t dir_rows[$];

  function automatic void add_row(logic [bks_pkg::CMD_W-1:0] c, logic [31:0] k, bit f,
                                  logic [bks_pkg::STAT_W-1:0] s, int occ);
    stim_row_t r;
    r.command = c;
    r.key = k;
    r.has_fixed = f;
    r.fixed.status = s;
    r.fixed.occupancy = 13'(occ);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    logic [31:0] pool_keys[$];
    int r, sel;
    logic [31:0] k;
    logic [bks_pkg::CMD_W-1:0] c;
    answer_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.command = bks_pkg::CMD_LOOKUP;
    in_ch.key = '0;
    set_clear();

    add_row(bks_pkg::CMD_LOOKUP, 32'd0, 1, bks_pkg::ST_ABSENT, 0);
    add_row(bks_pkg::CMD_ERASE, 32'hFFFFFFFF, 1, bks_pkg::ST_ABSENT, 0);
    add_row(bks_pkg::CMD_INSERT, 32'd0, 1, bks_pkg::ST_OK, 1);
    add_row(bks_pkg::CMD_INSERT, 32'd0, 1, bks_pkg::ST_DUP, 1);
    add_row(bks_pkg::CMD_INSERT, 32'hFFFFFFFF, 1, bks_pkg::ST_OK, 2);
    add_row(bks_pkg::CMD_INSERT, 32'd97, 1, bks_pkg::ST_OK, 3);
    add_row(bks_pkg::CMD_INSERT, 32'd194, 1, bks_pkg::ST_OK, 4);
    add_row(bks_pkg::CMD_LOOKUP, 32'd97, 1, bks_pkg::ST_OK, 4);
    // Erase of a run's head: the run restarts at its successor.
    add_row(bks_pkg::CMD_ERASE, 32'd0, 1, bks_pkg::ST_OK, 3);
    add_row(bks_pkg::CMD_LOOKUP, 32'd194, 1, bks_pkg::ST_OK, 3);
    add_row(bks_pkg::CMD_ERASE, 32'd194, 1, bks_pkg::ST_OK, 2);
    // Erase of a lone entry empties its bucket.
    add_row(bks_pkg::CMD_ERASE, 32'd97, 1, bks_pkg::ST_OK, 1);
    add_row(bks_pkg::CMD_LOOKUP, 32'd97, 1, bks_pkg::ST_ABSENT, 1);
    add_row(bks_pkg::CMD_INSERT, 32'd1, 0, bks_pkg::ST_OK, 0);
    add_row(bks_pkg::CMD_INSERT, 32'd98, 0, bks_pkg::ST_OK, 0);
    // Unused command code behaves as a look up.
    add_row(bks_pkg::CMD_SPARE, 32'd98, 1, bks_pkg::ST_OK, 3);
    add_row(bks_pkg::CMD_SPARE, 32'd5, 1, bks_pkg::ST_ABSENT, 3);
    add_row(bks_pkg::CMD_ERASE, 32'hFFFFFFFF, 1, bks_pkg::ST_OK, 2);
    add_row(bks_pkg::CMD_INSERT, 32'hAAAAAAAA, 0, bks_pkg::ST_OK, 0);
    add_row(bks_pkg::CMD_INSERT, 32'h55555555, 0, bks_pkg::ST_OK, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].command, dir_rows[i].key, dir_rows[i].has_fixed,
               dir_rows[i].fixed);
    pool_keys.insert(pool_keys.size(), 32'd1);
    pool_keys.insert(pool_keys.size(), 32'd98);

    // Random mix; half the keys reuse earlier ones and most of the rest crowd a few buckets.
    for (int i = 0; i < N_RAND; i++) begin
      no_idle = (i >= 300 && i < 420);
      r = $urandom_range(99);
      if (r < 45) c = bks_pkg::CMD_INSERT;
      else if (r < 70) c = bks_pkg::CMD_ERASE;
      else if (r < 95) c = bks_pkg::CMD_LOOKUP;
      else c = bks_pkg::CMD_SPARE;
      sel = $urandom_range(9);
      if (sel < 5 && pool_keys.size() > 0)
        k = pool_keys[$urandom_range(pool_keys.size() - 1)];
      else if (sel < 8) k = key_in_bucket($urandom_range(3));
      else k = $urandom();
      if (c == bks_pkg::CMD_INSERT) pool_keys.insert(pool_keys.size(), k);
      send_cmd(c, k, 1'b0, none);
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && stray == 0 && answers_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(12 * 5000000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
